@@ sv/pbb_pkg.sv @@
// Shared types, register codes and constants of the point bounding box block.
`default_nettype none
package pbb_pkg;

    localparam int CoordWidth   = 32;
    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 64;
    localparam int QueueDepth   = 8;
    localparam int ResultDepth  = 2;
    localparam int SumWidth     = 50;

    localparam logic signed [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
    localparam logic signed [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] RegXformEn   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegRow0Cols01 = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegRow0Cols23 = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegRow1Cols01 = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegRow1Cols23 = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegRow2Cols01 = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegRow2Cols23 = 3'd6;

    // identity matrix, no translation (1.0 in Q16.16 is 65536)
    localparam logic [CfgDataWidth-1:0] MatReset [6] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic signed [CoordWidth-1:0] pos_x;
        logic signed [CoordWidth-1:0] pos_y;
        logic signed [CoordWidth-1:0] pos_z;
        logic                         last_vertex;
    } t_pbb_in;

    typedef struct packed {
        logic signed [CoordWidth-1:0] min_x;
        logic signed [CoordWidth-1:0] min_y;
        logic signed [CoordWidth-1:0] min_z;
        logic signed [CoordWidth-1:0] max_x;
        logic signed [CoordWidth-1:0] max_y;
        logic signed [CoordWidth-1:0] max_z;
        logic        [CoordWidth-1:0] extent_x;
        logic        [CoordWidth-1:0] extent_y;
        logic        [CoordWidth-1:0] extent_z;
    } t_pbb_out;

endpackage
`default_nettype wire

@@ sv/pbb_fifo.sv @@
// Small flop-based FIFO used between the front and back and for results.
`default_nettype none
module pbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic                  o_full,
    output logic      [WIDTH-1:0] o_rdata
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/pbb_front.sv @@
// Front end: config registers, credit-gated intake and the affine transform pipeline.
`default_nettype none
module pbb_front #(
    parameter int QUEUE_DEPTH = pbb_pkg::QueueDepth
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pbb_pkg::CfgIdxWidth-1:0]   i_cfg_idx,
    input  wire logic [pbb_pkg::CfgDataWidth-1:0]  i_cfg_data,
    input  wire logic                              i_push,
    input  wire pbb_pkg::t_pbb_in                  i_item,
    input  wire logic                              i_release,
    output logic                                   o_full,
    output logic                                   o_valid,
    output pbb_pkg::t_pbb_in                       o_item
);

    localparam int Cw = pbb_pkg::CoordWidth;
    localparam int Sw = pbb_pkg::SumWidth;
    localparam int Pw = 2 * Cw;
    localparam int CrW = $clog2(QUEUE_DEPTH + 1);

    logic                               r_xform_en;
    logic [pbb_pkg::CfgDataWidth-1:0]   r_mat [6];
    logic [CrW-1:0]                     r_credit;

    logic                               accept;
    logic signed [Cw-1:0]               m [3][3];
    logic signed [Cw-1:0]               tr [3];
    logic signed [Cw-1:0]               pos [3];

    logic                               r1_valid;
    pbb_pkg::t_pbb_in                   r1_item;
    logic signed [Pw-1:0]               r1_prod [3][3];
    logic signed [Cw-1:0]               r1_trans [3];
    logic                               r1_xform;

    logic                               r2_valid;
    pbb_pkg::t_pbb_in                   r2_item;
    logic signed [Sw-1:0]               r2_sum [3];
    logic                               r2_xform;

    logic signed [Cw-1:0]               sat [3];

    // credits cover words in the pipeline plus words in the queue
    assign o_full = (r_credit == '0);
    assign accept = i_push && !o_full;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            m[r][0] = r_mat[2*r][Cw-1:0];
            m[r][1] = r_mat[2*r][2*Cw-1:Cw];
            m[r][2] = r_mat[2*r+1][Cw-1:0];
            tr[r]   = r_mat[2*r+1][2*Cw-1:Cw];
        end
        pos[0] = i_item.pos_x;
        pos[1] = i_item.pos_y;
        pos[2] = i_item.pos_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xform_en <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_mat[i] <= pbb_pkg::MatReset[i];
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pbb_pkg::RegXformEn: r_xform_en <= i_cfg_data[0];
                pbb_pkg::RegRow0Cols01, pbb_pkg::RegRow0Cols23,
                pbb_pkg::RegRow1Cols01, pbb_pkg::RegRow1Cols23,
                pbb_pkg::RegRow2Cols01, pbb_pkg::RegRow2Cols23:
                    r_mat[i_cfg_idx - 1'b1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CrW'(QUEUE_DEPTH);
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else begin
            case ({accept, i_release})
                2'b10:   r_credit <= r_credit - 1'b1;
                2'b01:   r_credit <= r_credit + 1'b1;
                default: r_credit <= r_credit;
            endcase
            r1_valid <= accept;
            r2_valid <= r1_valid;
        end
    end

    // stage 1: nine products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_item  <= i_item;
            r1_xform <= r_xform_en;
            for (int r = 0; r < 3; r++) begin
                r1_trans[r] <= tr[r];
                for (int c = 0; c < 3; c++) begin
                    r1_prod[r][c] <= pos[c] * m[r][c];
                end
            end
        end
    end

    // stage 2: floor each product to Q16.16 and sum exactly
    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r2_item  <= r1_item;
            r2_xform <= r1_xform;
            for (int r = 0; r < 3; r++) begin
                r2_sum[r] <= {{(Sw-Pw+16){r1_prod[r][0][Pw-1]}}, r1_prod[r][0][Pw-1:16]}
                           + {{(Sw-Pw+16){r1_prod[r][1][Pw-1]}}, r1_prod[r][1][Pw-1:16]}
                           + {{(Sw-Pw+16){r1_prod[r][2][Pw-1]}}, r1_prod[r][2][Pw-1:16]}
                           + {{(Sw-Cw){r1_trans[r][Cw-1]}}, r1_trans[r]};
            end
        end
    end

    // stage 3: saturate and pick raw or transformed
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (!r2_sum[r][Sw-1] && (r2_sum[r][Sw-2:Cw-1] != '0)) begin
                sat[r] = pbb_pkg::CoordMax;
            end else if (r2_sum[r][Sw-1] && (r2_sum[r][Sw-2:Cw-1] != '1)) begin
                sat[r] = pbb_pkg::CoordMin;
            end else begin
                sat[r] = r2_sum[r][Cw-1:0];
            end
        end
        o_item = r2_item;
        if (r2_xform) begin
            o_item.pos_x = sat[0];
            o_item.pos_y = sat[1];
            o_item.pos_z = sat[2];
        end
    end

    assign o_valid = r2_valid;

endmodule
`default_nettype wire

@@ sv/pbb_back.sv @@
// Back end: running min/max per axis and the result queue.
`default_nettype none
module pbb_back #(
    parameter int RESULT_DEPTH = pbb_pkg::ResultDepth
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_avail,
    input  wire pbb_pkg::t_pbb_in  i_item,
    output logic                   o_take,
    input  wire logic              i_pop,
    output logic                   o_empty,
    output pbb_pkg::t_pbb_out      o_result
);

    localparam int Cw = pbb_pkg::CoordWidth;

    logic signed [Cw-1:0] r_min [3];
    logic signed [Cw-1:0] r_max [3];
    logic signed [Cw-1:0] pos [3];
    logic signed [Cw-1:0] n_min [3];
    logic signed [Cw-1:0] n_max [3];

    logic               res_full;
    logic               res_push;
    pbb_pkg::t_pbb_out  res_word;

    // a last word only moves once the result queue has room
    assign o_take   = i_avail && (!i_item.last_vertex || !res_full);
    assign res_push = o_take && i_item.last_vertex;

    always_comb begin
        pos[0] = i_item.pos_x;
        pos[1] = i_item.pos_y;
        pos[2] = i_item.pos_z;
        for (int a = 0; a < 3; a++) begin
            n_min[a] = (pos[a] < r_min[a]) ? pos[a] : r_min[a];
            n_max[a] = (pos[a] > r_max[a]) ? pos[a] : r_max[a];
        end
        res_word.min_x    = n_min[0];
        res_word.min_y    = n_min[1];
        res_word.min_z    = n_min[2];
        res_word.max_x    = n_max[0];
        res_word.max_y    = n_max[1];
        res_word.max_z    = n_max[2];
        res_word.extent_x = n_max[0] - n_min[0];
        res_word.extent_y = n_max[1] - n_min[1];
        res_word.extent_z = n_max[2] - n_min[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= pbb_pkg::CoordMax;
                r_max[a] <= pbb_pkg::CoordMin;
            end
        end else if (o_take) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= i_item.last_vertex ? pbb_pkg::CoordMax : n_min[a];
                r_max[a] <= i_item.last_vertex ? pbb_pkg::CoordMin : n_max[a];
            end
        end
    end

    pbb_fifo #(
        .WIDTH ($bits(pbb_pkg::t_pbb_out)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_word),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_full  (res_full),
        .o_rdata (o_result)
    );

endmodule
`default_nettype wire

@@ sv/point_bounding_box.sv @@
// Running axis-aligned bounding box of a vertex stream, with optional affine transform.
//
// Input channel: a word is one vertex (x, y, z in signed Q16.16 plus a last flag),
// taken on a clock edge with push high and full low. While full is low, one vertex
// per cycle is sustained; the transform is three stages ahead of the min/max loop.
// Result channel: a word holds min, max and extent per axis and appears only for
// a vertex flagged last. It is shown while empty is low and taken with pop high.
// With no stall, empty falls once the last vertex is through the pipeline and queue.
// Config port: i_cfg_we, index, 64-bit data; user must write only while idle; no check.
// Index 0 enables the transform, 1 to 6 hold the matrix rows; others are ignored.
// When pop stays low, finished results collect in a two-word queue, vertices then
// fill an eight-word queue between the transform and the accumulator, and full
// rises once the queue and pipeline hold that many words. Nothing is lost.
// Reset (synchronous, active low) empties all queues, loads the identity matrix,
// turns the transform off and opens a fresh box.
`default_nettype none
module point_bounding_box #(
    parameter int QUEUE_DEPTH  = pbb_pkg::QueueDepth,
    parameter int RESULT_DEPTH = pbb_pkg::ResultDepth
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [pbb_pkg::CfgIdxWidth-1:0]   i_cfg_idx,
    input  wire logic [pbb_pkg::CfgDataWidth-1:0]  i_cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire pbb_pkg::t_pbb_in                  i_in,
    output logic                                   empty,
    input  wire logic                              pop,
    output pbb_pkg::t_pbb_out                      o_out
);

    logic              fr_valid;
    pbb_pkg::t_pbb_in  fr_item;
    logic              q_empty;
    logic              q_full;
    pbb_pkg::t_pbb_in  q_head;
    logic              bk_take;

    pbb_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_item     (i_in),
        .i_release  (bk_take),
        .o_full     (full),
        .o_valid    (fr_valid),
        .o_item     (fr_item)
    );

    // never overflows: the front holds a credit for every slot
    pbb_fifo #(
        .WIDTH ($bits(pbb_pkg::t_pbb_in)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_wdata (fr_item),
        .i_pop   (bk_take),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_rdata (q_head)
    );

    pbb_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!q_empty || q_full),
        .i_item   (q_head),
        .o_take   (bk_take),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (o_out)
    );

endmodule
`default_nettype wire

@@ dv/point_bounding_box_tb.sv @@
// Self-checking testbench for point_bounding_box: queued vertex stream, box prediction.
`timescale 1ns / 100ps
module point_bounding_box_tb;

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned DrainSettle = 8;
    // decoder has room for index 7, which the block must ignore
    localparam logic [pbb_pkg::CfgIdxWidth-1:0] RegUnused = 3'd7;

    typedef struct {
        pbb_pkg::t_pbb_in word;
        bit               drain_first;
    } t_pending_vertex;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic [pbb_pkg::CfgIdxWidth-1:0]     i_cfg_idx = '0;
    logic [pbb_pkg::CfgDataWidth-1:0]    i_cfg_data = '0;
    logic                                push = 1'b0;
    logic                                full;
    pbb_pkg::t_pbb_in                    i_in = '0;
    logic                                empty;
    logic                                pop = 1'b0;
    pbb_pkg::t_pbb_out                   o_out;

    // shadow of the block's registers and running box
    bit                                  xform_on = 1'b0;
    logic [pbb_pkg::CfgDataWidth-1:0]    mat_model [6] = pbb_pkg::MatReset;
    logic signed [pbb_pkg::CoordWidth-1:0] box_lo [3] =
        '{pbb_pkg::CoordMax, pbb_pkg::CoordMax, pbb_pkg::CoordMax};
    logic signed [pbb_pkg::CoordWidth-1:0] box_hi [3] =
        '{pbb_pkg::CoordMin, pbb_pkg::CoordMin, pbb_pkg::CoordMin};

    t_pending_vertex   pending_vertices [$];
    pbb_pkg::t_pbb_out expected_boxes [$];

    string field_name [9] = '{"extent_z", "extent_y", "extent_x", "max_z", "max_y", "max_x",
                              "min_z", "min_y", "min_x"};

    int unsigned mismatches = 0;
    int unsigned n_vertices = 0;
    int unsigned n_boxes = 0;
    int unsigned n_settings = 0;
    int unsigned n_cycles = 0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    point_bounding_box u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("Timeout after %0d cycles", n_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // mostly random gaps, with stretches of back-to-back words
    function automatic int unsigned draw_wait(inout bit burst);
        if ($urandom_range(0, 30) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 10);
    endfunction

    // one output axis: sum of floor(M*p / 2^16) plus translation, saturated at the end
    function automatic logic signed [pbb_pkg::CoordWidth-1:0] map_axis(
        input int r, input logic signed [pbb_pkg::CoordWidth-1:0] p [3]);
        logic signed [31:0] coef [4];
        logic signed [63:0] acc;
        logic signed [63:0] m_ext;
        logic signed [63:0] p_ext;
        coef[0] = mat_model[2*r][31:0];
        coef[1] = mat_model[2*r][63:32];
        coef[2] = mat_model[2*r+1][31:0];
        coef[3] = mat_model[2*r+1][63:32];
        acc = coef[3];
        for (int k = 0; k < 3; k++) begin
            m_ext = coef[k];
            p_ext = p[k];
            acc += (m_ext * p_ext) >>> 16;
        end
        if (acc > pbb_pkg::CoordMax) return pbb_pkg::CoordMax;
        if (acc < pbb_pkg::CoordMin) return pbb_pkg::CoordMin;
        return acc[pbb_pkg::CoordWidth-1:0];
    endfunction

    function automatic void fold_vertex(input pbb_pkg::t_pbb_in v);
        logic signed [pbb_pkg::CoordWidth-1:0] raw [3];
        logic signed [pbb_pkg::CoordWidth-1:0] pt [3];
        pbb_pkg::t_pbb_out b;
        raw[0] = v.pos_x;
        raw[1] = v.pos_y;
        raw[2] = v.pos_z;
        for (int a = 0; a < 3; a++) begin
            pt[a] = xform_on ? map_axis(a, raw) : raw[a];
            if (pt[a] < box_lo[a]) box_lo[a] = pt[a];
            if (pt[a] > box_hi[a]) box_hi[a] = pt[a];
        end
        if (!v.last_vertex) return;
        b.min_x = box_lo[0];
        b.min_y = box_lo[1];
        b.min_z = box_lo[2];
        b.max_x = box_hi[0];
        b.max_y = box_hi[1];
        b.max_z = box_hi[2];
        b.extent_x = box_hi[0] - box_lo[0];
        b.extent_y = box_hi[1] - box_lo[1];
        b.extent_z = box_hi[2] - box_lo[2];
        expected_boxes.push_back(b);
        box_lo = '{pbb_pkg::CoordMax, pbb_pkg::CoordMax, pbb_pkg::CoordMax};
        box_hi = '{pbb_pkg::CoordMin, pbb_pkg::CoordMin, pbb_pkg::CoordMin};
    endfunction

    task automatic compare_box(input pbb_pkg::t_pbb_out got);
        pbb_pkg::t_pbb_out want;
        logic [8:0][pbb_pkg::CoordWidth-1:0] g;
        logic [8:0][pbb_pkg::CoordWidth-1:0] w;
        if (expected_boxes.size() == 0) begin
            report_mismatch("result word with no box pending");
            return;
        end
        want = expected_boxes.pop_front();
        g = got;
        w = want;
        for (int i = 0; i < 9; i++)
            if (g[i] !== w[i])
                report_mismatch($sformatf("box %0d %s: got %h, want %h",
                                          n_boxes, field_name[i], g[i], w[i]));
    endtask

    // vertex driver
    always @(posedge i_clk) begin : vertex_driver
        logic go;
        t_pending_vertex nxt;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            go = push && full;
            if (push && !full) begin
                fold_vertex(i_in);
                n_vertices++;
                send_wait = draw_wait(send_burst);
            end
            if (!go) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_vertices.size() != 0 &&
                             !(pending_vertices[0].drain_first && expected_boxes.size() != 0)) begin
                    nxt = pending_vertices.pop_front();
                    i_in <= nxt.word;
                    go = 1'b1;
                end
            end
            push <= go;
        end
    end

    // box monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                compare_box(o_out);
                n_boxes++;
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait > 0) begin
                recv_wait--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic queue_vertex(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z, input bit last, input bit drain);
        t_pending_vertex pv;
        pv.word.pos_x = x;
        pv.word.pos_y = y;
        pv.word.pos_z = z;
        pv.word.last_vertex = last;
        pv.drain_first = drain;
        pending_vertices.push_back(pv);
    endtask

    function automatic logic [31:0] pick_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return pbb_pkg::CoordMax;
            1: return pbb_pkg::CoordMin;
            2, 3, 4: return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic logic [31:0] pick_entry(input int unsigned kind);
        logic [31:0] r;
        r = $urandom;
        if (kind == 0) return r;
        if (kind == 1) return {{12{r[19]}}, r[19:0]};
        case ($urandom_range(0, 5))
            0: return pbb_pkg::CoordMax;
            1: return pbb_pkg::CoordMin;
            2: return 32'h0000_0000;
            3: return 32'h0001_0000;
            4: return 32'hFFFF_0000;
            default: return 32'h0000_8000;
        endcase
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_vertices.size() != 0 || push || expected_boxes.size() != 0);
        repeat (DrainSettle) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [pbb_pkg::CfgIdxWidth-1:0] idx,
                             input logic [63:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == pbb_pkg::RegXformEn) xform_on = data[0];
        else if (idx <= pbb_pkg::RegRow2Cols23) mat_model[idx - 1] = data;
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic configure(input bit en, input int unsigned kind);
        logic [63:0] d;
        logic [pbb_pkg::CfgIdxWidth-1:0] idx;
        d = {$urandom, $urandom};
        d[0] = en;
        cfg_write(pbb_pkg::RegXformEn, d);
        idx = pbb_pkg::RegRow0Cols01;
        for (int r = 0; r < 6; r++) begin
            cfg_write(idx, {pick_entry(kind), pick_entry(kind)});
            idx = idx + 1'b1;
        end
        if ($urandom_range(0, 1)) cfg_write(RegUnused, {$urandom, $urandom});
        cfg_close();
    endtask

    task automatic queue_random_boxes(input int unsigned n_items, input int unsigned drain_at);
        int unsigned k;
        int unsigned len;
        k = 0;
        while (k < n_items) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            for (int unsigned j = 0; j < len; j++) begin
                queue_vertex(pick_coord(), pick_coord(), pick_coord(), j == len - 1,
                             k == drain_at);
                k++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // raw positions: single-vertex box, full-range box, sign crossings, bit patterns
        queue_vertex(pbb_pkg::CoordMax, pbb_pkg::CoordMin, 32'h0, 1'b1, 1'b0);
        queue_vertex(pbb_pkg::CoordMin, pbb_pkg::CoordMin, pbb_pkg::CoordMin, 1'b0, 1'b0);
        queue_vertex(pbb_pkg::CoordMax, pbb_pkg::CoordMax, pbb_pkg::CoordMax, 1'b1, 1'b0);
        queue_vertex(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b0, 1'b0);
        queue_vertex(32'h1, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0);
        queue_vertex(32'h0, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 1'b1, 1'b0);
        wait_idle();

        // transform on with the reset identity matrix; upper enable bits are don't-care
        cfg_write(pbb_pkg::RegXformEn, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_close();
        queue_vertex(pbb_pkg::CoordMax, pbb_pkg::CoordMin, 32'h1234_5678, 1'b1, 1'b0);
        wait_idle();

        // extreme coefficients: saturation both ways, translation alone, floor of negatives
        cfg_write(pbb_pkg::RegRow0Cols01, {pbb_pkg::CoordMax, pbb_pkg::CoordMax});
        cfg_write(pbb_pkg::RegRow0Cols23, {pbb_pkg::CoordMax, pbb_pkg::CoordMax});
        cfg_write(pbb_pkg::RegRow1Cols01, {pbb_pkg::CoordMin, pbb_pkg::CoordMin});
        cfg_write(pbb_pkg::RegRow1Cols23, {pbb_pkg::CoordMin, pbb_pkg::CoordMin});
        cfg_write(pbb_pkg::RegRow2Cols01, {32'hFFFF_8000, 32'h0000_8000});
        cfg_write(pbb_pkg::RegRow2Cols23, {32'h0000_0000, 32'h0000_8000});
        cfg_write(RegUnused, 64'h0001_0000_0001_0000);
        cfg_close();
        queue_vertex(pbb_pkg::CoordMax, pbb_pkg::CoordMax, pbb_pkg::CoordMax, 1'b0, 1'b0);
        queue_vertex(pbb_pkg::CoordMin, pbb_pkg::CoordMin, pbb_pkg::CoordMin, 1'b1, 1'b0);
        queue_vertex(pbb_pkg::CoordMax, pbb_pkg::CoordMin, 32'h0, 1'b1, 1'b0);
        queue_vertex(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        queue_vertex(32'h1, 32'h1, 32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_vertex(32'hFFFF_FFFF, 32'h1, 32'h3, 1'b1, 1'b0);

        // random phases over several settings; one phase holds the sender for a full drain
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            configure(ph != 2, ph % 3);
            queue_random_boxes(106, (ph == 3) ? 50 : 32'hFFFF_FFFF);
        end
        wait_idle();

        $display("Checked %0d boxes from %0d vertices over %0d register settings,",
                 n_boxes, n_vertices, n_settings);
        $display("raw and transformed, with saturating coefficients and random stalls.");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/pbb_pkg.sv
sv/pbb_fifo.sv
sv/pbb_front.sv
sv/pbb_back.sv
sv/point_bounding_box.sv
dv/point_bounding_box_tb.sv
